@@ hw/rtl/intel_hex_loader_byte_swap_macros.svh @@
// Assertion macros used by the loader RTL.
`ifndef INTEL_HEX_LOADER_BYTE_SWAP_MACROS_SVH
`define INTEL_HEX_LOADER_BYTE_SWAP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define IHBS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ihbs check failed");

// Next-cycle implication, checked outside reset.
`define IHBS_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ihbs check failed");

`endif

@@ hw/rtl/ihbs_pkg.sv @@
// Types, constants and helpers of the Intel HEX loader.
package ihbs_pkg;

    localparam int unsigned ROM_BYTES = 524288;
    localparam int POS_W     = 10;
    localparam int ADDR_W    = 19;

    localparam logic [POS_W-1:0] POS_MAX = '1;

    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_COLON   = 8'h3A;

    localparam logic [7:0] REC_DATA = 8'h00;
    localparam logic [7:0] REC_EOF  = 8'h01;
    localparam logic [7:0] REC_ELA  = 8'h04;

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_END   = 1'b1;

    typedef enum logic [1:0] {
        LM_START  = 2'd0,
        LM_RECORD = 2'd1,
        LM_SKIP   = 2'd2
    } t_line_mode;

    // Hex digit value, anything else reads as zero.
    function automatic logic [3:0] digit_value(input logic [7:0] c);
        logic [3:0] v;
        v = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = 4'(c - 8'h30);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            v = 4'(c - 8'h37);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            v = 4'(c - 8'h57);
        end
        return v;
    endfunction

endpackage

@@ hw/rtl/intel_hex_loader_byte_swap.sv @@
// Intel HEX loader with 16-bit byte swap: character decode and result register.
//
// Input channel i_valid/o_ready/i_ch takes one text character per request.
// Output channel o_valid/i_ready carries o_kind, o_rom_address, o_rom_byte:
// a byte write to ROM (address low bit flipped) or an end-of-file mark.
// Each accepted character updates the line decoder in the same cycle; a
// result it causes is registered and appears on the output in the cycle after the accept.
// Throughput is one character per cycle: o_ready stays high while the
// result register is empty or being taken, so a character may enter in
// the same cycle the previous result leaves.
// If the receiver stalls with a result held, o_ready drops until it is
// taken; characters that cause no result are still stalled then.
// After an end record the block keeps taking characters and ignores them
// until reset. Reset (synchronous, active low) clears the decoder, the
// address base and the result register; no clearing pass is needed.
// Writes whose full address or swapped address reach the ROM size are dropped.
module intel_hex_loader_byte_swap (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [7:0]                  i_ch,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic                        o_kind,
    output logic [ihbs_pkg::ADDR_W-1:0] o_rom_address,
    output logic [7:0]                  o_rom_byte
);

`include "intel_hex_loader_byte_swap_macros.svh"

    ihbs_pkg::t_line_mode        r_mode, n_mode;
    logic [ihbs_pkg::POS_W-1:0]  r_pos, n_pos;
    logic [7:0]                  r_length, n_length;
    logic [15:0]                 r_offset, n_offset;
    logic [7:0]                  r_rkind, n_rkind;
    logic [15:0]                 r_upper, n_upper;
    logic [15:0]                 r_pending, n_pending;
    logic [3:0]                  r_hnib, n_hnib;
    logic [7:0]                  r_done, n_done;
    logic                        r_committed, n_committed;
    logic                        r_finished, n_finished;

    logic                        r_out_valid, n_out_valid;
    logic                        r_out_kind, n_out_kind;
    logic [ihbs_pkg::ADDR_W-1:0] r_out_addr, n_out_addr;
    logic [7:0]                  r_out_byte, n_out_byte;

    logic        accept;
    logic        emit;
    logic        is_nl;
    logic        is_colon;
    logic [3:0]  d;
    logic [7:0]  kind_new;
    logic [31:0] full;
    logic [31:0] swapped;
    logic [15:0] pend_add;
    logic [15:0] pend_new;

    assign o_ready  = !r_out_valid || i_ready;
    assign accept   = i_valid && o_ready;
    assign is_nl    = (i_ch == ihbs_pkg::CH_NEWLINE);
    assign is_colon = (i_ch == ihbs_pkg::CH_COLON);
    assign d        = ihbs_pkg::digit_value(i_ch);
    assign kind_new = {r_rkind[3:0], d};
    assign full     = {r_upper, r_offset} + {24'd0, r_done};
    assign swapped  = {full[31:1], ~full[0]};

    always_comb begin
        unique case (r_pos[1:0])
            2'd1:    pend_add = {d, 12'd0};
            2'd2:    pend_add = {4'd0, d, 8'd0};
            2'd3:    pend_add = {8'd0, d, 4'd0};
            default: pend_add = {12'd0, d};
        endcase
        pend_new = r_pending | pend_add;
    end

    // Line mode next state.
    always_comb begin
        n_mode = r_mode;
        if (accept && !r_finished) begin
            if (is_nl) begin
                n_mode = ihbs_pkg::LM_START;
            end else if (r_mode == ihbs_pkg::LM_START) begin
                n_mode = is_colon ? ihbs_pkg::LM_RECORD : ihbs_pkg::LM_SKIP;
            end
        end
    end

    // Record fields, counters and result.
    always_comb begin
        n_pos       = r_pos;
        n_length    = r_length;
        n_offset    = r_offset;
        n_rkind     = r_rkind;
        n_upper     = r_upper;
        n_pending   = r_pending;
        n_hnib      = r_hnib;
        n_done      = r_done;
        n_committed = r_committed;
        n_finished  = r_finished;
        emit        = 1'b0;
        n_out_kind  = ihbs_pkg::KIND_WRITE;
        n_out_addr  = swapped[ihbs_pkg::ADDR_W-1:0];
        n_out_byte  = {r_hnib, d};

        if (accept && !r_finished) begin
            if (is_nl) begin
                if (r_mode == ihbs_pkg::LM_RECORD && r_pos >= 10'd9 &&
                    r_rkind == ihbs_pkg::REC_ELA && !r_committed) begin
                    n_upper = r_pending;
                end
                n_pos = '0;
            end else if (r_mode == ihbs_pkg::LM_START) begin
                n_pos = 10'd1;
                if (is_colon) begin
                    n_length    = '0;
                    n_offset    = '0;
                    n_rkind     = '0;
                    n_pending   = '0;
                    n_hnib      = '0;
                    n_done      = '0;
                    n_committed = 1'b0;
                end
            end else begin
                n_pos = (r_pos == ihbs_pkg::POS_MAX) ? r_pos : r_pos + 10'd1;
                if (r_mode == ihbs_pkg::LM_RECORD) begin
                    priority if (r_pos <= 10'd2) begin
                        n_length = {r_length[3:0], d};
                    end else if (r_pos <= 10'd6) begin
                        n_offset = {r_offset[11:0], d};
                    end else if (r_pos <= 10'd8) begin
                        n_rkind = kind_new;
                        if (r_pos == 10'd8 && kind_new == ihbs_pkg::REC_EOF) begin
                            n_finished = 1'b1;
                            emit       = 1'b1;
                            n_out_kind = ihbs_pkg::KIND_END;
                            n_out_addr = '0;
                            n_out_byte = '0;
                        end
                    end else if (r_rkind == ihbs_pkg::REC_DATA) begin
                        if (r_pos[0]) begin
                            n_hnib = d;
                        end else if (r_done < r_length) begin
                            n_done = r_done + 8'd1;
                            emit   = (full < 32'(ihbs_pkg::ROM_BYTES)) &&
                                     (swapped < 32'(ihbs_pkg::ROM_BYTES));
                        end
                    end else if (r_rkind == ihbs_pkg::REC_ELA && r_pos <= 10'd12 &&
                                 !r_committed) begin
                        n_pending = pend_new;
                        if (r_pos == 10'd12) begin
                            n_upper     = pend_new;
                            n_committed = 1'b1;
                        end
                    end else begin
                        n_pos = n_pos;
                    end
                end
            end
        end

        if (emit) begin
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= ihbs_pkg::LM_START;
            r_pos       <= '0;
            r_length    <= '0;
            r_offset    <= '0;
            r_rkind     <= '0;
            r_upper     <= '0;
            r_pending   <= '0;
            r_hnib      <= '0;
            r_done      <= '0;
            r_committed <= 1'b0;
            r_finished  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_mode      <= n_mode;
            r_pos       <= n_pos;
            r_length    <= n_length;
            r_offset    <= n_offset;
            r_rkind     <= n_rkind;
            r_upper     <= n_upper;
            r_pending   <= n_pending;
            r_hnib      <= n_hnib;
            r_done      <= n_done;
            r_committed <= n_committed;
            r_finished  <= n_finished;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_kind <= n_out_kind;
            r_out_addr <= n_out_addr;
            r_out_byte <= n_out_byte;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_kind        = r_out_kind;
    assign o_rom_address = r_out_addr;
    assign o_rom_byte    = r_out_byte;

    `IHBS_ASSERT_IMP(a_end_last, r_finished && r_out_valid, r_out_kind == ihbs_pkg::KIND_END)
    `IHBS_ASSERT_IMP(a_done_le_len, 1'b1, r_done <= r_length)
    `IHBS_ASSERT_IMP(a_commit_ela, r_committed, r_rkind == ihbs_pkg::REC_ELA)
    `IHBS_ASSERT_NXT(a_drain, r_out_valid && i_ready && !emit, !r_out_valid)

endmodule

@@ bench/intel_hex_loader_byte_swap_checker.sv @@
// Checker for the Intel HEX loader: predicts ROM requests and compares them.
module intel_hex_loader_byte_swap_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic                        i_in_ready,
    input  logic [7:0]                  i_ch,
    input  logic                        i_out_valid,
    input  logic                        i_out_ready,
    input  logic                        i_kind,
    input  logic [ihbs_pkg::ADDR_W-1:0] i_rom_address,
    input  logic [7:0]                  i_rom_byte,
    output int                          o_fail_count,
    output int                          o_expected_left
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic                        kind;
        logic [ihbs_pkg::ADDR_W-1:0] addr;
        logic [7:0]                  data;
    } t_rom_req;

    t_rom_req     expected_reqs[$];
    int           mismatches;

    logic [ihbs_pkg::POS_W-1:0] pos;
    ihbs_pkg::t_line_mode       mode;
    logic [7:0]                 rec_len;
    logic [15:0]                rec_off;
    logic [7:0]                 rec_kind;
    logic [15:0]                base_hi;
    logic [15:0]                base_pend;
    logic [3:0]                 hi_nib;
    logic [7:0]                 pairs_done;
    logic                       base_loaded;
    logic                       eof_seen;

    function automatic logic [3:0] nibble_of(input logic [7:0] c);
        logic [3:0] v;
        v = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = c[3:0];
        end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
            v = c[3:0] + 4'd9;
        end
        return v;
    endfunction

    task automatic clear_decoder();
        pos         = '0;
        mode        = ihbs_pkg::LM_START;
        rec_len     = '0;
        rec_off     = '0;
        rec_kind    = '0;
        base_hi     = '0;
        base_pend   = '0;
        hi_nib      = '0;
        pairs_done  = '0;
        base_loaded = 1'b0;
        eof_seen    = 1'b0;
    endtask

    // Advance the line decoder by one character, queue the ROM request it causes.
    task automatic decode_char(input logic [7:0] c);
        logic [ihbs_pkg::POS_W-1:0] p;
        logic [3:0]                 d;
        logic [31:0]                full;
        logic [31:0]                swapped;
        t_rom_req                   r;
        if (eof_seen) return;
        if (c == ihbs_pkg::CH_NEWLINE) begin
            if (mode == ihbs_pkg::LM_RECORD && pos >= 9 && rec_kind == ihbs_pkg::REC_ELA &&
                !base_loaded) begin
                base_hi = base_pend;
            end
            mode = ihbs_pkg::LM_START;
            pos  = '0;
            return;
        end
        if (mode == ihbs_pkg::LM_START) begin
            pos = 1;
            if (c == ihbs_pkg::CH_COLON) begin
                mode        = ihbs_pkg::LM_RECORD;
                rec_len     = '0;
                rec_off     = '0;
                rec_kind    = '0;
                base_pend   = '0;
                hi_nib      = '0;
                pairs_done  = '0;
                base_loaded = 1'b0;
            end else begin
                mode = ihbs_pkg::LM_SKIP;
            end
            return;
        end
        p = pos;
        if (pos != ihbs_pkg::POS_MAX) begin
            pos = pos + 1'b1;
        end
        if (mode != ihbs_pkg::LM_RECORD) return;
        d = nibble_of(c);
        if (p <= 2) begin
            rec_len = {rec_len[3:0], d};
        end else if (p <= 6) begin
            rec_off = {rec_off[11:0], d};
        end else if (p <= 8) begin
            rec_kind = {rec_kind[3:0], d};
            if (p == 8 && rec_kind == ihbs_pkg::REC_EOF) begin
                eof_seen = 1'b1;
                r.kind = ihbs_pkg::KIND_END;
                r.addr = '0;
                r.data = '0;
                expected_reqs.push_back(r);
            end
        end else if (rec_kind == ihbs_pkg::REC_DATA) begin
            if (p[0]) begin
                hi_nib = d;
            end else if (pairs_done < rec_len) begin
                full    = ({base_hi, 16'h0000} | {16'h0000, rec_off}) + {24'h0, pairs_done};
                swapped = full ^ 32'd1;
                pairs_done = pairs_done + 1'b1;
                if (full < ihbs_pkg::ROM_BYTES && swapped < ihbs_pkg::ROM_BYTES) begin
                    r.kind = ihbs_pkg::KIND_WRITE;
                    r.addr = swapped[ihbs_pkg::ADDR_W-1:0];
                    r.data = {hi_nib, d};
                    expected_reqs.push_back(r);
                end
            end
        end else if (rec_kind == ihbs_pkg::REC_ELA && p <= 12 && !base_loaded) begin
            base_pend = base_pend | (16'(d) << (4 * (12 - p)));
            if (p == 12) begin
                base_hi     = base_pend;
                base_loaded = 1'b1;
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_rom_req exp_req;
        if (!i_rst_n) begin
            clear_decoder();
            expected_reqs.delete();
            mismatches = 0;
        end else begin
            if (i_in_valid && i_in_ready) begin
                decode_char(i_ch);
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_reqs.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("ERROR %0t: unexpected request kind %0d addr %05h byte %02h",
                                 $time, i_kind, i_rom_address, i_rom_byte);
                    end
                end else begin
                    exp_req = expected_reqs.pop_front();
                    if (exp_req.kind !== i_kind || exp_req.addr !== i_rom_address ||
                        exp_req.data !== i_rom_byte) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("ERROR %0t: exp kind %0d addr %05h byte %02h, got %0d %05h %02h",
                                     $time, exp_req.kind, exp_req.addr, exp_req.data,
                                     i_kind, i_rom_address, i_rom_byte);
                        end
                    end
                end
            end
        end
        o_fail_count    <= mismatches;
        o_expected_left <= expected_reqs.size();
    end

endmodule

@@ bench/intel_hex_loader_byte_swap_tb.sv @@
// Testbench top for the Intel HEX loader: clock, reset, character stream and verdict.
module intel_hex_loader_byte_swap_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [7:0] REC_ESA = 8'h05;
    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam int HOLDOFF_CYCLES  = 400;

    logic                        clk;
    logic                        rst_n;
    logic                        in_valid;
    logic                        in_ready;
    logic [7:0]                  in_ch;
    logic                        out_valid;
    logic                        out_ready;
    logic                        out_kind;
    logic [ihbs_pkg::ADDR_W-1:0] out_rom_address;
    logic [7:0]                  out_rom_byte;
    int                          fail_count;
    int                          expected_left;

    int                sent_chars;
    bit                sender_quiet;
    bit                pressure_req;

    intel_hex_loader_byte_swap i_dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_valid      (in_valid),
        .o_ready      (in_ready),
        .i_ch         (in_ch),
        .o_valid      (out_valid),
        .i_ready      (out_ready),
        .o_kind       (out_kind),
        .o_rom_address(out_rom_address),
        .o_rom_byte   (out_rom_byte)
    );

    intel_hex_loader_byte_swap_checker i_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .i_in_ready     (in_ready),
        .i_ch           (in_ch),
        .i_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .i_kind         (out_kind),
        .i_rom_address  (out_rom_address),
        .i_rom_byte     (out_rom_byte),
        .o_fail_count   (fail_count),
        .o_expected_left(expected_left)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        #10ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic int pick_idle();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return 0;
        if (r < 92) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    function automatic logic [7:0] noise_char();
        logic [7:0] c;
        do c = 8'($urandom); while (c == ihbs_pkg::CH_NEWLINE);
        return c;
    endfunction

    // Hex digit in either case; a zero digit is sometimes sent as a non-hex character.
    function automatic logic [7:0] digit_char(input logic [3:0] v);
        logic [7:0] c;
        if (v == 4'd0 && $urandom_range(0, 3) == 0) begin
            do c = noise_char();
            while ((c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
                   (c >= 8'h61 && c <= 8'h66));
        end else if (v < 4'd10) begin
            c = 8'h30 + v;
        end else if ($urandom_range(0, 1) == 1) begin
            c = 8'h37 + v;
        end else begin
            c = 8'h57 + v;
        end
        return c;
    endfunction

    task automatic put_char(input logic [7:0] c);
        int n;
        n = sender_quiet ? 0 : pick_idle();
        if (n > 0) begin
            @(negedge clk);
            in_valid <= 1'b0;
            in_ch    <= 8'($urandom);
            repeat (n - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid <= 1'b1;
        in_ch    <= c;
        do @(posedge clk); while (!in_ready);
        sent_chars++;
    endtask

    task automatic send_str(input string s);
        for (int i = 0; i < s.len(); i++) begin
            put_char(s[i]);
        end
    endtask

    task automatic send_hex_byte(input logic [7:0] v);
        put_char(digit_char(v[7:4]));
        put_char(digit_char(v[3:0]));
    endtask

    task automatic end_line();
        if ($urandom_range(0, 4) == 0) begin
            put_char(CH_CR);
        end
        put_char(ihbs_pkg::CH_NEWLINE);
    endtask

    task automatic send_header(input logic [7:0] count, input logic [15:0] off,
                               input logic [7:0] kind);
        put_char(ihbs_pkg::CH_COLON);
        send_hex_byte(count);
        send_hex_byte(off[15:8]);
        send_hex_byte(off[7:0]);
        send_hex_byte(kind);
    endtask

    task automatic send_record(input logic [7:0] kind, input logic [7:0] count,
                               input logic [15:0] off, input int nbytes, input bit odd_tail);
        send_header(count, off, kind);
        repeat (nbytes) send_hex_byte(8'($urandom));
        if (odd_tail) begin
            put_char(digit_char(4'($urandom)));
        end
        end_line();
    endtask

    task automatic send_base(input logic [15:0] b, input int ndig);
        send_header(8'h02, 16'h0000, ihbs_pkg::REC_ELA);
        for (int i = 0; i < ndig; i++) begin
            put_char(digit_char(b[15 - 4 * i -: 4]));
        end
        if (ndig == 4) begin
            send_hex_byte(8'($urandom));
        end
        end_line();
    endtask

    // Receiver: random stalls, quiet stretches, and one long hold-off on request.
    initial begin
        int  hold_left;
        bit  ready_quiet;
        bit  pressure_done;
        hold_left     = 0;
        ready_quiet   = 1'b0;
        pressure_done = 1'b0;
        out_ready     = 1'b0;
        wait (rst_n);
        forever begin
            @(negedge clk);
            if ($urandom_range(0, 199) == 0) ready_quiet = !ready_quiet;
            if (hold_left > 0) begin
                out_ready <= 1'b0;
                hold_left--;
            end else if (pressure_req && !pressure_done) begin
                pressure_done = 1'b1;
                hold_left     = HOLDOFF_CYCLES;
                out_ready     <= 1'b0;
            end else begin
                out_ready <= 1'b1;
                hold_left = ready_quiet ? 0 : pick_idle();
            end
        end
    end

    initial begin
        int          sel;
        int          n;
        logic [7:0]  k;
        logic [15:0] b;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        in_ch        = 8'h00;
        sent_chars   = 0;
        sender_quiet = 1'b0;
        pressure_req = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed lines
        send_str(":030000000000FF7E80\n");
        send_str(":04fff000a1b2c3d4e5\r\n");
        send_str(":020000040007F1\n");
        send_str(":04FFFE00112233445E\n");
        send_str(":02000004FFFFFC\n");
        send_str(":04FFFE0055667788AA\n");
        send_str(":020000047\n");
        send_str(":0100000099\n");
        send_str(":02000004\n");
        send_str(":04001000ABCDE\n");
        send_str(":0100200011223344\n");
        send_str(":04000005123456780A\n");
        send_str(":027F00FF1234\n");
        send_str(":0200\n");
        send_str("x:0200000012345\n");
        send_str(":z1zz10z0AB\n");
        send_str(":00004000\n");
        send_str("\n");
        send_str(":01005000");
        put_char(8'h80);
        put_char(8'h37);
        put_char(ihbs_pkg::CH_NEWLINE);
        send_header(8'hFF, 16'h0040, ihbs_pkg::REC_DATA);
        repeat (1040) put_char(digit_char(4'($urandom)));
        end_line();

        // random lines; the receiver holds off early so the block backs up
        pressure_req = 1'b1;
        while (sent_chars < 1720) begin
            if ($urandom_range(0, 19) == 0) sender_quiet = !sender_quiet;
            sel = $urandom_range(0, 99);
            if (sel < 60) begin
                n = $urandom_range(0, 16);
                send_record(ihbs_pkg::REC_DATA, 8'(n), 16'($urandom),
                            n + 1 + (($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : 0),
                            1'b0);
            end else if (sel < 72) begin
                b = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 7));
                send_base(b, ($urandom_range(0, 4) == 0) ? $urandom_range(0, 3) : 4);
            end else if (sel < 80) begin
                n = $urandom_range(1, 16);
                send_record(ihbs_pkg::REC_DATA, ($urandom_range(0, 7) == 0) ? 8'hFF : 8'(n),
                            16'($urandom), $urandom_range(0, n - 1), 1'($urandom));
            end else if (sel < 86) begin
                if ($urandom_range(0, 2) == 0) begin
                    k = REC_ESA;
                end else begin
                    do k = 8'($urandom);
                    while (k == ihbs_pkg::REC_DATA || k == ihbs_pkg::REC_EOF ||
                           k == ihbs_pkg::REC_ELA);
                end
                send_record(k, 8'($urandom_range(0, 8)), 16'($urandom),
                            $urandom_range(0, 8), 1'b0);
            end else if (sel < 92) begin
                put_char(ihbs_pkg::CH_COLON);
                repeat ($urandom_range(0, 7)) put_char(digit_char(4'($urandom)));
                put_char(ihbs_pkg::CH_NEWLINE);
            end else begin
                if ($urandom_range(0, 3) != 0) begin
                    do k = noise_char(); while (k == ihbs_pkg::CH_COLON);
                    put_char(k);
                    repeat ($urandom_range(0, 20)) put_char(noise_char());
                end
                put_char(ihbs_pkg::CH_NEWLINE);
            end
        end

        // end record, then a line that must be ignored
        send_str(":00000001FF\n");
        send_str(":0100600042\n");
        @(negedge clk);
        in_valid <= 1'b0;

        wait (expected_left == 0);
        repeat (20) @(posedge clk);
        if (fail_count == 0 && expected_left == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
